// ===== design/solf_pkg.sv =====
// Shared types, codes and the arithmetic program of the second-order lag/lead filter.
package solf_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int COUNT_MODULUS_DEF = 10000;
  localparam int US_PER_S          = 1000000;

  // Configuration register indexes
  localparam logic [2:0] CFG_GAIN      = 3'd0;
  localparam logic [2:0] CFG_NAT_FREQ  = 3'd1;
  localparam logic [2:0] CFG_DAMPING   = 3'd2;
  localparam logic [2:0] CFG_LEAD1     = 3'd3;
  localparam logic [2:0] CFG_LEAD2     = 3'd4;
  localparam logic [2:0] CFG_CYCLE_US  = 3'd5;
  localparam logic [2:0] CFG_INIT_OUT  = 3'd6;
  localparam logic [2:0] CFG_INIT_PREV = 3'd7;

  // Micro-operations on the accumulator
  localparam logic [3:0] OP_LDA   = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_ST    = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_SHL1  = 4'd5;
  localparam logic [3:0] OP_SHLF  = 4'd6;
  localparam logic [3:0] OP_SHL2F = 4'd7;
  localparam logic [3:0] OP_DIV   = 4'd8;
  localparam logic [3:0] OP_END   = 4'd9;

  // Wide operand selects (load/add/sub source, store destination)
  localparam logic [3:0] SEL_W    = 4'd0;
  localparam logic [3:0] SEL_P    = 4'd1;
  localparam logic [3:0] SEL_B1   = 4'd2;
  localparam logic [3:0] SEL_B2   = 4'd3;
  localparam logic [3:0] SEL_CS   = 4'd4;
  localparam logic [3:0] SEL_TMP  = 4'd5;
  localparam logic [3:0] SEL_DEN  = 4'd6;
  localparam logic [3:0] SEL_TW   = 4'd7;
  localparam logic [3:0] SEL_B1PM = 4'd8;
  localparam logic [3:0] SEL_B2M2 = 4'd9;
  localparam logic [3:0] SEL_CU1  = 4'd10;
  localparam logic [3:0] SEL_INP  = 4'd11;
  localparam logic [3:0] SEL_NUM  = 4'd12;

  // Multiplier operand selects
  localparam logic [3:0] Y_P  = 4'd0;
  localparam logic [3:0] Y_W  = 4'd1;
  localparam logic [3:0] Y_TH = 4'd2;
  localparam logic [3:0] Y_M  = 4'd3;
  localparam logic [3:0] Y_K  = 4'd4;
  localparam logic [3:0] Y_U  = 4'd5;
  localparam logic [3:0] Y_U1 = 4'd6;
  localparam logic [3:0] Y_U2 = 4'd7;
  localparam logic [3:0] Y_V1 = 4'd8;
  localparam logic [3:0] Y_V2 = 4'd9;

  localparam int PCW      = 6;
  localparam int PROG_LEN = 61;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] sel;
  } uop_t;

  typedef struct packed {
    logic       issue;
    logic [3:0] op;
    logic [3:0] sel;
    logic       capture;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic run_filter;
  } stat_t;

  typedef struct packed {
    logic [31:0] gain;
    logic [30:0] nat_freq;
    logic [30:0] damping;
    logic [31:0] lead1;
    logic [31:0] lead2;
    logic [31:0] cycle_us;
    logic [31:0] init_out;
    logic [31:0] init_prev;
  } cfg_t;

  // Program: den = S^2*(W^2P^2 + 2*TH*W*P*M + S^2M^2), num as the exact ratio form
  function automatic uop_t ucode(input logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OP_LDA,   SEL_W};
      6'd1:  u = '{OP_MUL,   Y_P};
      6'd2:  u = '{OP_ST,    SEL_TMP};
      6'd3:  u = '{OP_MUL,   Y_W};
      6'd4:  u = '{OP_MUL,   Y_P};
      6'd5:  u = '{OP_ST,    SEL_DEN};
      6'd6:  u = '{OP_LDA,   SEL_TMP};
      6'd7:  u = '{OP_MUL,   Y_TH};
      6'd8:  u = '{OP_MUL,   Y_M};
      6'd9:  u = '{OP_SHL1,  SEL_W};
      6'd10: u = '{OP_ST,    SEL_TW};
      6'd11: u = '{OP_ADD,   SEL_DEN};
      6'd12: u = '{OP_ADD,   SEL_CS};
      6'd13: u = '{OP_SHL2F, SEL_W};
      6'd14: u = '{OP_ST,    SEL_DEN};
      6'd15: u = '{OP_LDA,   SEL_B1};
      6'd16: u = '{OP_MUL,   Y_P};
      6'd17: u = '{OP_MUL,   Y_M};
      6'd18: u = '{OP_ST,    SEL_B1PM};
      6'd19: u = '{OP_LDA,   SEL_B2};
      6'd20: u = '{OP_MUL,   Y_M};
      6'd21: u = '{OP_MUL,   Y_M};
      6'd22: u = '{OP_ST,    SEL_B2M2};
      6'd23: u = '{OP_SHL1,  SEL_W};
      6'd24: u = '{OP_ADD,   SEL_B1PM};
      6'd25: u = '{OP_ST,    SEL_CU1};
      6'd26: u = '{OP_LDA,   SEL_P};
      6'd27: u = '{OP_MUL,   Y_P};
      6'd28: u = '{OP_SHLF,  SEL_W};
      6'd29: u = '{OP_ADD,   SEL_B1PM};
      6'd30: u = '{OP_ADD,   SEL_B2M2};
      6'd31: u = '{OP_MUL,   Y_U};
      6'd32: u = '{OP_ST,    SEL_INP};
      6'd33: u = '{OP_LDA,   SEL_CU1};
      6'd34: u = '{OP_MUL,   Y_U1};
      6'd35: u = '{OP_ST,    SEL_TMP};
      6'd36: u = '{OP_LDA,   SEL_INP};
      6'd37: u = '{OP_SUB,   SEL_TMP};
      6'd38: u = '{OP_ST,    SEL_INP};
      6'd39: u = '{OP_LDA,   SEL_B2M2};
      6'd40: u = '{OP_MUL,   Y_U2};
      6'd41: u = '{OP_ADD,   SEL_INP};
      6'd42: u = '{OP_MUL,   Y_K};
      6'd43: u = '{OP_MUL,   Y_W};
      6'd44: u = '{OP_MUL,   Y_W};
      6'd45: u = '{OP_ST,    SEL_NUM};
      6'd46: u = '{OP_LDA,   SEL_TW};
      6'd47: u = '{OP_ADD,   SEL_CS};
      6'd48: u = '{OP_ADD,   SEL_CS};
      6'd49: u = '{OP_SHL2F, SEL_W};
      6'd50: u = '{OP_MUL,   Y_V1};
      6'd51: u = '{OP_ADD,   SEL_NUM};
      6'd52: u = '{OP_ST,    SEL_NUM};
      6'd53: u = '{OP_LDA,   SEL_CS};
      6'd54: u = '{OP_SHL2F, SEL_W};
      6'd55: u = '{OP_MUL,   Y_V2};
      6'd56: u = '{OP_ST,    SEL_TMP};
      6'd57: u = '{OP_LDA,   SEL_NUM};
      6'd58: u = '{OP_SUB,   SEL_TMP};
      6'd59: u = '{OP_DIV,   SEL_W};
      default: u = '{OP_END, SEL_W};
    endcase
    return u;
  endfunction

endpackage

// ===== design/solf_dp.sv =====
// Datapath: history, accumulator, temporaries, serial multiplier and divider.
module solf_dp
  import solf_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int COUNT_MODULUS = COUNT_MODULUS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic [31:0] sample,
  input  logic        en,
  input  logic        hold,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic [31:0] filtered,
  output logic        enable_out,
  output logic [13:0] tick_count
);

  localparam int WD   = 216 + FRAC_BITS;
  localparam int DCW  = $clog2(WD);
  localparam int CW   = $clog2(COUNT_MODULUS);
  localparam logic [WD-1:0] CS = WD'(64'd1000000000000) << (2 * FRAC_BITS);
  localparam logic [32:0]   YM = 33'(US_PER_S);

  localparam logic [1:0] DPH_IDLE  = 2'd0;
  localparam logic [1:0] DPH_ITER  = 2'd1;
  localparam logic [1:0] DPH_ROUND = 2'd2;
  localparam logic [1:0] DPH_SAT   = 2'd3;

  // captured item
  logic [31:0] sample_r;
  logic        en_r, hold_r;
  // filter history
  logic [31:0] in_p1_r, in_p2_r, out_p1_r, out_p2_r, out_now_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  // accumulator and temporaries
  logic [WD-1:0] acc_r, tmp_r, den_r, tw_r, b1pm_r, b2m2_r, cu1_r, inp_r, num_r;
  // multiplier
  logic [WD-1:0] mcand_r;
  logic [32:0]   y_r;
  logic [5:0]    mcnt_r;
  logic          mbusy_r;
  // divider
  logic [WD-1:0] dvd_r, rem_r;
  logic [DCW-1:0] dcnt_r;
  logic [1:0]    dph_r;
  logic          neg_r;
  logic [31:0]   filt_r;
  logic          done_r;
  // result
  logic [31:0]   filtered_r;
  logic          enable_out_r;
  logic [13:0]   tick_r;

  logic [WD-1:0] src_val, addend, sat_dummy;
  logic [32:0]   y_val;
  logic [WD:0]   rem2, rem2_sub;
  logic          ge, rnd;
  logic [31:0]   sat_val, new_out;

  // wide operand select
  always_comb begin
    case (cmd.sel)
      SEL_W:    src_val = WD'(cfg.nat_freq);
      SEL_P:    src_val = WD'(cfg.cycle_us);
      SEL_B1:   src_val = {{(WD-32){cfg.lead1[31]}}, cfg.lead1};
      SEL_B2:   src_val = {{(WD-32){cfg.lead2[31]}}, cfg.lead2};
      SEL_CS:   src_val = CS;
      SEL_TMP:  src_val = tmp_r;
      SEL_DEN:  src_val = den_r;
      SEL_TW:   src_val = tw_r;
      SEL_B1PM: src_val = b1pm_r;
      SEL_B2M2: src_val = b2m2_r;
      SEL_CU1:  src_val = cu1_r;
      SEL_INP:  src_val = inp_r;
      SEL_NUM:  src_val = num_r;
      default:  src_val = '0;
    endcase
  end

  // multiplier operand select, 33-bit signed
  always_comb begin
    case (cmd.sel)
      Y_P:     y_val = {1'b0, cfg.cycle_us};
      Y_W:     y_val = {2'b00, cfg.nat_freq};
      Y_TH:    y_val = {2'b00, cfg.damping};
      Y_M:     y_val = YM;
      Y_K:     y_val = {cfg.gain[31], cfg.gain};
      Y_U:     y_val = {sample_r[31], sample_r};
      Y_U1:    y_val = {in_p1_r[31], in_p1_r};
      Y_U2:    y_val = {in_p2_r[31], in_p2_r};
      Y_V1:    y_val = {out_p1_r[31], out_p1_r};
      Y_V2:    y_val = {out_p2_r[31], out_p2_r};
      default: y_val = '0;
    endcase
  end

  // one multiplier bit, MSB first; the sign bit has negative weight
  always_comb begin
    if (!y_r[32])            addend = '0;
    else if (mcnt_r == 6'd32) addend = '0 - mcand_r;
    else                     addend = mcand_r;
  end

  // one divider bit
  assign rem2     = {rem_r, dvd_r[WD-1]};
  assign rem2_sub = rem2 - {1'b0, den_r};
  assign ge       = (rem2 >= {1'b0, den_r});
  assign rnd      = ({rem_r, 1'b0} >= {1'b0, den_r});

  // clamp the rounded magnitude to 32 bits
  always_comb begin
    sat_dummy = acc_r;
    if (!neg_r) begin
      sat_val = (|sat_dummy[WD-1:31]) ? 32'h7FFF_FFFF : sat_dummy[31:0];
    end else if ((|sat_dummy[WD-1:32]) || (sat_dummy[31] && (|sat_dummy[30:0]))) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'd0 - sat_dummy[31:0];
    end
  end

  // arithmetic sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      dph_r   <= DPH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.issue) begin
        case (cmd.op)
          OP_LDA:   acc_r <= src_val;
          OP_ADD:   acc_r <= acc_r + src_val;
          OP_SUB:   acc_r <= acc_r - src_val;
          OP_SHL1:  acc_r <= acc_r << 1;
          OP_SHLF:  acc_r <= acc_r << FRAC_BITS;
          OP_SHL2F: acc_r <= acc_r << (2 * FRAC_BITS);
          OP_ST: begin
            case (cmd.sel)
              SEL_TMP:  tmp_r  <= acc_r;
              SEL_DEN:  den_r  <= acc_r;
              SEL_TW:   tw_r   <= acc_r;
              SEL_B1PM: b1pm_r <= acc_r;
              SEL_B2M2: b2m2_r <= acc_r;
              SEL_CU1:  cu1_r  <= acc_r;
              SEL_INP:  inp_r  <= acc_r;
              SEL_NUM:  num_r  <= acc_r;
              default:  tmp_r  <= tmp_r;
            endcase
          end
          OP_MUL: begin
            mcand_r <= acc_r;
            acc_r   <= '0;
            y_r     <= y_val;
            mcnt_r  <= 6'd32;
            mbusy_r <= 1'b1;
          end
          OP_DIV: begin
            neg_r  <= acc_r[WD-1];
            dvd_r  <= acc_r[WD-1] ? ('0 - acc_r) : acc_r;
            rem_r  <= '0;
            dcnt_r <= DCW'(WD - 1);
            dph_r  <= DPH_ITER;
          end
          default: acc_r <= acc_r;
        endcase
      end else if (mbusy_r) begin
        acc_r <= {acc_r[WD-2:0], 1'b0} + addend;
        y_r   <= {y_r[31:0], 1'b0};
        if (mcnt_r == 6'd0) begin
          mbusy_r <= 1'b0;
          done_r  <= 1'b1;
        end else begin
          mcnt_r <= mcnt_r - 6'd1;
        end
      end else begin
        case (dph_r)
          DPH_ITER: begin
            rem_r <= ge ? rem2_sub[WD-1:0] : rem2[WD-1:0];
            dvd_r <= {dvd_r[WD-2:0], ge};
            if (dcnt_r == '0) dph_r <= DPH_ROUND;
            else              dcnt_r <= dcnt_r - DCW'(1);
          end
          DPH_ROUND: begin
            acc_r <= dvd_r + WD'(rnd);
            dph_r <= DPH_SAT;
          end
          DPH_SAT: begin
            filt_r <= sat_val;
            dph_r  <= DPH_IDLE;
            done_r <= 1'b1;
          end
          default: dph_r <= DPH_IDLE;
        endcase
      end
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample;
      en_r     <= en;
      hold_r   <= hold;
    end
  end

  // counter wrap
  always_comb begin
    if (cnt_r == CW'(COUNT_MODULUS - 1)) cnt_nxt = '0;
    else                                  cnt_nxt = cnt_r + CW'(1);
  end

  always_comb begin
    if (!en_r)       new_out = out_now_r;
    else if (hold_r) new_out = cfg.init_out;
    else             new_out = filt_r;
  end

  // history shift and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_p1_r   <= '0;
      in_p2_r   <= '0;
      out_p1_r  <= '0;
      out_p2_r  <= '0;
      out_now_r <= '0;
      cnt_r     <= '0;
    end else if (cmd.commit) begin
      in_p2_r   <= in_p1_r;
      in_p1_r   <= sample_r;
      out_p2_r  <= (en_r && hold_r) ? cfg.init_prev : out_p1_r;
      out_p1_r  <= new_out;
      out_now_r <= new_out;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      filtered_r   <= new_out;
      enable_out_r <= en_r;
      tick_r       <= 14'(cnt_nxt);
    end
  end

  assign stat.unit_done  = done_r;
  assign stat.run_filter = en_r && !hold_r;
  assign filtered        = filtered_r;
  assign enable_out      = enable_out_r;
  assign tick_count      = tick_r;

`ifndef SYNTHESIS
  // multiplier and divider never run together
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mbusy_r && (dph_r != DPH_IDLE)))
    else $error("multiplier and divider both busy");
  // no new operation while a unit is busy
  a_no_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (!mbusy_r && (dph_r == DPH_IDLE)))
    else $error("operation issued to busy unit");
  // counter stays in range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(COUNT_MODULUS - 1))
    else $error("tick counter out of range");
`endif

endmodule

// ===== design/solf_ctrl.sv =====
// Controller: handshake and program sequencer for the filter datapath.
module solf_ctrl
  import solf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  output logic  out_tvalid,
  input  logic  out_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [PCW-1:0] pc_r, pc_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;
  uop_t           uop;
  logic           slot_free;

  assign uop       = ucode(pc_r);
  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    cmd.issue   = 1'b0;
    cmd.op      = uop.op;
    cmd.sel     = uop.sel;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        pc_nxt    = '0;
        state_nxt = stat.run_filter ? ST_EXEC : ST_FIN;
      end
      ST_EXEC: begin
        if (uop.op == OP_END) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.issue = 1'b1;
          if (uop.op == OP_MUL || uop.op == OP_DIV) state_nxt = ST_WAIT;
          else                                      pc_nxt    = pc_r + PCW'(1);
        end
      end
      ST_WAIT: begin
        if (stat.unit_done) begin
          pc_nxt    = pc_r + PCW'(1);
          state_nxt = ST_EXEC;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result slot
  always_comb begin
    if (cmd.commit)      out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else                 out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

`ifndef SYNTHESIS
  // a result only enters a free slot
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid_r || out_tready))
    else $error("result overwrites pending transaction");
  // one item at a time
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while busy");
  // program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> (pc_r <= PCW'(PROG_LEN - 1)))
    else $error("program counter out of range");
  // unit completion only while waiting on it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.unit_done |-> (state_r == ST_WAIT))
    else $error("unexpected unit completion");
`endif

endmodule

// ===== design/second_order_lag_lead_filter.sv =====
// Top level: configuration registers, controller and datapath of the lag/lead filter.
//
// Second-order lag/lead element, one Q16.16 sample in, one Q16.16 result out.
// Input channel in_*: one transaction per control tick (sample, enable, hold_reset).
// Output channel out_*: one transaction per input (filtered, enable_out, tick_count).
// Configuration: cfg_we/cfg_addr/cfg_wdata, write only, while no item is in flight.
// Items are processed one at a time. A filtered tick runs 41 simple steps, 18
// multiplies on a shared bit-serial multiplier and a restoring divide (one quotient
// bit per cycle over the 216+FRAC_BITS bit word); a disabled or hold-reset tick
// skips this arithmetic program.
// The exact ratio of wide integers is rounded to nearest, ties away from zero,
// and clamped to 32 bits.
// The next input is taken as soon as the result sits in the output register;
// while the receiver stalls with a result pending, a finished result waits in the
// datapath and no further input is accepted.
// Reset (rst_n low, synchronous) clears the history, the tick counter and the
// handshake state and loads the register defaults.
module second_order_lag_lead_filter
  import solf_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int COUNT_MODULUS = COUNT_MODULUS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample
  input  logic [1:0]  in_tuser,   // [0] enable, [1] hold_reset
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] filtered, [45:32] tick_count, [47:46] zero
  output logic [0:0]  out_tuser,  // [0] enable_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  cfg_t        cfg_r;
  cmd_t        cmd;
  stat_t       stat;
  logic [31:0] filtered;
  logic        enable_out;
  logic [13:0] tick_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= 32'd1 << FRAC_BITS;
      cfg_r.nat_freq  <= 31'd1 << FRAC_BITS;
      cfg_r.damping   <= 31'd1 << FRAC_BITS;
      cfg_r.lead1     <= '0;
      cfg_r.lead2     <= '0;
      cfg_r.cycle_us  <= 32'(US_PER_S);
      cfg_r.init_out  <= '0;
      cfg_r.init_prev <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GAIN:      cfg_r.gain      <= cfg_wdata;
        CFG_NAT_FREQ:  cfg_r.nat_freq  <= cfg_wdata[30:0];
        CFG_DAMPING:   cfg_r.damping   <= cfg_wdata[30:0];
        CFG_LEAD1:     cfg_r.lead1     <= cfg_wdata;
        CFG_LEAD2:     cfg_r.lead2     <= cfg_wdata;
        CFG_CYCLE_US:  cfg_r.cycle_us  <= cfg_wdata;
        CFG_INIT_OUT:  cfg_r.init_out  <= cfg_wdata;
        CFG_INIT_PREV: cfg_r.init_prev <= cfg_wdata;
        default:       cfg_r.gain      <= cfg_r.gain;
      endcase
    end
  end

  solf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  solf_dp #(
    .FRAC_BITS     (FRAC_BITS),
    .COUNT_MODULUS (COUNT_MODULUS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .sample     (in_tdata),
    .en         (in_tuser[0]),
    .hold       (in_tuser[1]),
    .cmd        (cmd),
    .stat       (stat),
    .filtered   (filtered),
    .enable_out (enable_out),
    .tick_count (tick_count)
  );

  // result transaction packing
  assign out_tdata = {2'b00, tick_count, filtered};
  assign out_tuser = enable_out;

endmodule
